// ----- rtl/tknn_pkg.sv -----
`timescale 1ns / 1ps

package tknn_pkg;

   // Sizing of the kept list and of the distance lanes.
   localparam int K_MAX     = 16;
   localparam int EMB_LANES = 4;

   localparam int ELEM_W = 16;
   localparam int ID_W   = 32;
   localparam int ABS_W  = ELEM_W;
   localparam int SQ_W   = 2 * ABS_W;
   localparam int DIST_W = SQ_W + ((EMB_LANES > 1) ? $clog2(EMB_LANES) : 0);

   localparam int KCNT_W = $clog2(K_MAX + 1);
   localparam int KIDX_W = (K_MAX > 1) ? $clog2(K_MAX) : 1;

   // Queue between the distance pipeline and the selector; depth is a power of two.
   localparam int QDEPTH = 8;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   // Register indexes; the byte address is four times the index.
   localparam logic [CSR_IDX_W-1:0] REG_K_USED   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_EMB_LEN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_QUERY_0  = 3'd2;

   typedef struct packed {
      logic [KCNT_W-1:0]                 k_eff;
      logic [EMB_LANES-1:0]              lane_en;
      logic [EMB_LANES-1:0][ELEM_W-1:0]  query;
   } tknn_cfg_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [DIST_W-1:0] sqdist;
      logic              last;
   } tknn_cand_type;

endpackage

// ----- rtl/tknn_csr.sv -----
`timescale 1ns / 1ps

module tknn_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [tknn_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [tknn_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [tknn_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready,
   output tknn_pkg::tknn_cfg_type                cfg
);

   logic [4:0] k_used_ff, k_used_in;
   logic [2:0] emb_len_ff, emb_len_in;
   logic [tknn_pkg::EMB_LANES-1:0][tknn_pkg::ELEM_W-1:0] query_ff, query_in;
   logic                                wr;
   logic [tknn_pkg::CSR_IDX_W-1:0]      reg_idx;

   assign wr      = psel && penable && pwrite;
   assign reg_idx = paddr[tknn_pkg::CSR_IDX_W+1:2];
   assign pready  = 1'b1;

   always_comb begin
      k_used_in  = k_used_ff;
      emb_len_in = emb_len_ff;
      query_in   = query_ff;
      if (wr) begin
         if (reg_idx == tknn_pkg::REG_K_USED) begin
            k_used_in = pwdata[4:0];
         end
         if (reg_idx == tknn_pkg::REG_EMB_LEN) begin
            emb_len_in = pwdata[2:0];
         end
         for (int i = 0; i < tknn_pkg::EMB_LANES; i++) begin
            if (reg_idx == tknn_pkg::CSR_IDX_W'(tknn_pkg::REG_QUERY_0 + i)) begin
               query_in[i] = pwdata[tknn_pkg::ELEM_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_used_ff  <= 5'(tknn_pkg::K_MAX);
         emb_len_ff <= 3'(tknn_pkg::EMB_LANES);
         query_ff   <= '0;
      end else begin
         k_used_ff  <= k_used_in;
         emb_len_ff <= emb_len_in;
         query_ff   <= query_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx == tknn_pkg::REG_K_USED) begin
         prdata = tknn_pkg::CSR_DATA_W'(k_used_ff);
      end
      if (reg_idx == tknn_pkg::REG_EMB_LEN) begin
         prdata = tknn_pkg::CSR_DATA_W'(emb_len_ff);
      end
      for (int i = 0; i < tknn_pkg::EMB_LANES; i++) begin
         if (reg_idx == tknn_pkg::CSR_IDX_W'(tknn_pkg::REG_QUERY_0 + i)) begin
            prdata = tknn_pkg::CSR_DATA_W'(query_ff[i]);
         end
      end
   end

   // Out-of-range settings are clamped here so that the datapath sees legal values only.
   always_comb begin
      if (k_used_ff == '0) begin
         cfg.k_eff = tknn_pkg::KCNT_W'(1);
      end else if (int'(k_used_ff) > tknn_pkg::K_MAX) begin
         cfg.k_eff = tknn_pkg::KCNT_W'(tknn_pkg::K_MAX);
      end else begin
         cfg.k_eff = tknn_pkg::KCNT_W'(k_used_ff);
      end
      for (int i = 0; i < tknn_pkg::EMB_LANES; i++) begin
         cfg.lane_en[i] = (i == 0) || (int'(emb_len_ff) > i);
      end
      cfg.query = query_ff;
   end

endmodule

// ----- rtl/tknn_front.sv -----
`timescale 1ns / 1ps

module tknn_front (
   input  logic                                              clock,
   input  logic                                              reset,
   input  tknn_pkg::tknn_cfg_type                            cfg,
   input  logic                                              in_valid,
   output logic                                              in_ready,
   input  logic [tknn_pkg::ID_W-1:0]                         in_id,
   input  logic [tknn_pkg::EMB_LANES-1:0][tknn_pkg::ELEM_W-1:0] in_elem,
   input  logic                                              in_last,
   input  logic [tknn_pkg::QCNT_W-1:0]                       q_count,
   output logic                                              push,
   output tknn_pkg::tknn_cand_type                           push_data
);

   logic accept;

   logic                                                  v1_ff, v2_ff, v3_ff;
   logic [tknn_pkg::ID_W-1:0]                             id1_ff, id2_ff, id3_ff;
   logic                                                  last1_ff, last2_ff, last3_ff;
   logic [tknn_pkg::EMB_LANES-1:0][tknn_pkg::ABS_W-1:0]   absd1_ff, absd1_in;
   logic [tknn_pkg::EMB_LANES-1:0][tknn_pkg::SQ_W-1:0]    sq2_ff, sq2_in;
   logic [tknn_pkg::DIST_W-1:0]                           sum3_ff, sum3_in;
   logic [tknn_pkg::QCNT_W+1:0]                           committed;

   // Every item in the pipeline has a queue slot reserved, so the pipeline never stalls.
   assign committed = (tknn_pkg::QCNT_W+2)'(q_count) + (tknn_pkg::QCNT_W+2)'(v1_ff)
                    + (tknn_pkg::QCNT_W+2)'(v2_ff) + (tknn_pkg::QCNT_W+2)'(v3_ff);
   assign in_ready  = committed < (tknn_pkg::QCNT_W+2)'(tknn_pkg::QDEPTH);
   assign accept    = in_valid && in_ready;

   always_comb begin
      logic signed [tknn_pkg::ELEM_W:0] diff;
      for (int i = 0; i < tknn_pkg::EMB_LANES; i++) begin
         diff = $signed({in_elem[i][tknn_pkg::ELEM_W-1], in_elem[i]})
              - $signed({cfg.query[i][tknn_pkg::ELEM_W-1], cfg.query[i]});
         if (!cfg.lane_en[i]) begin
            absd1_in[i] = '0;
         end else if (diff[tknn_pkg::ELEM_W]) begin
            absd1_in[i] = tknn_pkg::ABS_W'(-diff);
         end else begin
            absd1_in[i] = diff[tknn_pkg::ABS_W-1:0];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < tknn_pkg::EMB_LANES; i++) begin
         sq2_in[i] = tknn_pkg::SQ_W'(absd1_ff[i]) * tknn_pkg::SQ_W'(absd1_ff[i]);
      end
   end

   always_comb begin
      sum3_in = '0;
      for (int i = 0; i < tknn_pkg::EMB_LANES; i++) begin
         sum3_in = sum3_in + tknn_pkg::DIST_W'(sq2_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      id1_ff   <= in_id;
      last1_ff <= in_last;
      absd1_ff <= absd1_in;
      id2_ff   <= id1_ff;
      last2_ff <= last1_ff;
      sq2_ff   <= sq2_in;
      id3_ff   <= id2_ff;
      last3_ff <= last2_ff;
      sum3_ff  <= sum3_in;
   end

   assign push             = v3_ff;
   assign push_data.id     = id3_ff;
   assign push_data.sqdist = sum3_ff;
   assign push_data.last   = last3_ff;

endmodule

// ----- rtl/tknn_queue.sv -----
`timescale 1ns / 1ps

module tknn_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  tknn_pkg::tknn_cand_type           push_data,
   input  logic                              pop,
   output logic                              head_valid,
   output tknn_pkg::tknn_cand_type           head_data,
   output logic [tknn_pkg::QCNT_W-1:0]       count
);

   tknn_pkg::tknn_cand_type           mem_ff [tknn_pkg::QDEPTH];
   logic [tknn_pkg::QPTR_W-1:0]       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [tknn_pkg::QCNT_W-1:0]       count_ff, count_in;

   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

   assign head_valid = count_ff != '0;
   assign head_data  = mem_ff[rptr_ff];
   assign count      = count_ff;

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff < tknn_pkg::QCNT_W'(tknn_pkg::QDEPTH))
      else $error("queue written while full");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue read while empty");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow a write");

endmodule

// ----- rtl/tknn_select.sv -----
`timescale 1ns / 1ps

module tknn_select (
   input  logic                              clock,
   input  logic                              reset,
   input  tknn_pkg::tknn_cfg_type            cfg,
   input  logic                              head_valid,
   input  tknn_pkg::tknn_cand_type           head_data,
   output logic                              pop,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [tknn_pkg::ID_W-1:0]         out_id,
   output logic [tknn_pkg::DIST_W-1:0]       out_dist,
   output logic                              out_last
);

   // Kept list, nearest first, one entry per cell.
   logic [tknn_pkg::DIST_W-1:0] kd_ff  [tknn_pkg::K_MAX];
   logic [tknn_pkg::DIST_W-1:0] kd_in  [tknn_pkg::K_MAX];
   logic [tknn_pkg::ID_W-1:0]   kid_ff [tknn_pkg::K_MAX];
   logic [tknn_pkg::ID_W-1:0]   kid_in [tknn_pkg::K_MAX];
   logic [tknn_pkg::DIST_W-1:0] ins_kd  [tknn_pkg::K_MAX];
   logic [tknn_pkg::ID_W-1:0]   ins_kid [tknn_pkg::K_MAX];
   logic [tknn_pkg::KCNT_W-1:0] kcount_ff, kcount_in;

   // Snapshot of a finished set, read out while the next set fills the list.
   logic [tknn_pkg::DIST_W-1:0] dd_ff  [tknn_pkg::K_MAX];
   logic [tknn_pkg::ID_W-1:0]   did_ff [tknn_pkg::K_MAX];
   logic [tknn_pkg::KCNT_W-1:0] drain_cnt_ff, drain_cnt_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tknn_pkg::ID_W-1:0]   rsp_id_ff;
   logic [tknn_pkg::DIST_W-1:0] rsp_dist_ff;
   logic                        rsp_last_ff;

   logic [tknn_pkg::K_MAX-1:0]  le;
   logic [tknn_pkg::KCNT_W-1:0] n_cur, cnt_ins;
   logic [tknn_pkg::KIDX_W-1:0] k_last_idx, drain_idx;
   logic                        drop, drain_busy, load_out, set_end;

   assign drain_busy = drain_cnt_ff != '0;
   assign pop        = head_valid && !(head_data.last && drain_busy);
   assign set_end    = pop && head_data.last;
   assign load_out   = drain_busy && (!rsp_valid_ff || out_ready);
   assign k_last_idx = tknn_pkg::KIDX_W'(cfg.k_eff - tknn_pkg::KCNT_W'(1));
   assign drain_idx  = tknn_pkg::KIDX_W'(drain_cnt_ff - tknn_pkg::KCNT_W'(1));

   // Every cell compares at once; the entries at or below the new distance stay, the
   // first one above takes the candidate, and the rest move one place down.
   always_comb begin
      n_cur = (kcount_ff > cfg.k_eff) ? cfg.k_eff : kcount_ff;
      for (int i = 0; i < tknn_pkg::K_MAX; i++) begin
         le[i] = (tknn_pkg::KCNT_W'(i) < n_cur) && (kd_ff[i] <= head_data.sqdist);
      end
      drop = le[k_last_idx];
      if (le[0]) begin
         ins_kd[0]  = kd_ff[0];
         ins_kid[0] = kid_ff[0];
      end else begin
         ins_kd[0]  = head_data.sqdist;
         ins_kid[0] = head_data.id;
      end
      for (int i = 1; i < tknn_pkg::K_MAX; i++) begin
         if (le[i]) begin
            ins_kd[i]  = kd_ff[i];
            ins_kid[i] = kid_ff[i];
         end else if (le[i-1]) begin
            ins_kd[i]  = head_data.sqdist;
            ins_kid[i] = head_data.id;
         end else begin
            ins_kd[i]  = kd_ff[i-1];
            ins_kid[i] = kid_ff[i-1];
         end
      end
      if (drop || !(n_cur < cfg.k_eff)) begin
         cnt_ins = n_cur;
      end else begin
         cnt_ins = n_cur + 1'b1;
      end
   end

   always_comb begin
      for (int i = 0; i < tknn_pkg::K_MAX; i++) begin
         kd_in[i]  = pop ? ins_kd[i] : kd_ff[i];
         kid_in[i] = pop ? ins_kid[i] : kid_ff[i];
      end
      kcount_in = kcount_ff;
      if (set_end) begin
         kcount_in = '0;
      end else if (pop) begin
         kcount_in = cnt_ins;
      end
      drain_cnt_in = drain_cnt_ff;
      if (set_end) begin
         drain_cnt_in = cnt_ins;
      end else if (load_out) begin
         drain_cnt_in = drain_cnt_ff - 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kcount_ff    <= '0;
         drain_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kcount_ff    <= kcount_in;
         drain_cnt_ff <= drain_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kd_ff  <= kd_in;
      kid_ff <= kid_in;
      if (set_end) begin
         dd_ff  <= ins_kd;
         did_ff <= ins_kid;
      end
      if (load_out) begin
         rsp_id_ff   <= did_ff[drain_idx];
         rsp_dist_ff <= dd_ff[drain_idx];
         rsp_last_ff <= drain_cnt_ff == tknn_pkg::KCNT_W'(1);
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_id    = rsp_id_ff;
   assign out_dist  = rsp_dist_ff;
   assign out_last  = rsp_last_ff;

   a_set_end_hands_off : assert property (@(posedge clock) disable iff (reset)
      set_end |=> drain_cnt_ff != '0 && kcount_ff == '0)
      else $error("finished set was not handed to the drain");

   a_final_marked_last : assert property (@(posedge clock) disable iff (reset)
      load_out && drain_cnt_ff == tknn_pkg::KCNT_W'(1) |=> rsp_valid_ff && rsp_last_ff)
      else $error("closest entry of a set went out without the last mark");

   a_insert_counts : assert property (@(posedge clock) disable iff (reset)
      pop && !head_data.last && !drop |=> kcount_ff != '0)
      else $error("inserted candidate left an empty list");

endmodule

// ----- rtl/top_k_nearest_by_squared_distance_unit.sv -----
`timescale 1ns / 1ps

// Keeps the k_used candidates nearest to the query vector by squared Euclidean distance
// and, after the candidate marked last_item, reports them farthest first with result_last
// on the closest one. Candidates are taken one per cycle while req_ready is high: a
// three-stage distance pipeline (difference, square, lane sum) feeds an eight-entry
// queue, and a sorted list of K_MAX compare-and-shift cells inserts one candidate per
// cycle. A finished set is copied into a drain buffer and read out at one result per
// cycle while rsp_ready is high, so the next set keeps streaming in. Only a further
// last-marked candidate waits in the queue until the previous set has been fully
// handed to the output register, which can hold req_ready low when the queue fills.
module top_k_nearest_by_squared_distance_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_cand_id,
   input  logic [15:0] req_elem_0,
   input  logic [15:0] req_elem_1,
   input  logic [15:0] req_elem_2,
   input  logic [15:0] req_elem_3,
   input  logic        req_last_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_id,
   output logic [33:0] rsp_result_distance,
   output logic        rsp_result_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   tknn_pkg::tknn_cfg_type                               cfg;
   tknn_pkg::tknn_cand_type                              push_data, head_data;
   logic                                                 push, pop, head_valid;
   logic [tknn_pkg::QCNT_W-1:0]                          q_count;
   logic [tknn_pkg::EMB_LANES-1:0][tknn_pkg::ELEM_W-1:0] elems;
   logic [tknn_pkg::DIST_W-1:0]                          out_dist;

   assign elems = {req_elem_3, req_elem_2, req_elem_1, req_elem_0};

   tknn_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   tknn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_id     (req_cand_id),
      .in_elem   (elems),
      .in_last   (req_last_item),
      .q_count   (q_count),
      .push      (push),
      .push_data (push_data)
   );

   tknn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data),
      .count      (q_count)
   );

   tknn_select u_select (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_id     (rsp_result_id),
      .out_dist   (out_dist),
      .out_last   (rsp_result_last)
   );

   assign rsp_result_distance = 34'(out_dist);

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   typedef struct {
      logic [31:0]       id;
      logic [3:0][15:0]  elem;
      logic              last;
   } cand_item_type;

   typedef struct {
      logic [31:0] id;
      logic [33:0] sqdist;
      logic        last;
   } nearest_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_cand_id = '0;
   logic [15:0] req_elem_0 = '0;
   logic [15:0] req_elem_1 = '0;
   logic [15:0] req_elem_2 = '0;
   logic [15:0] req_elem_3 = '0;
   logic        req_last_item = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_result_id;
   logic [33:0] rsp_result_distance;
   logic        rsp_result_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Search settings as the block should see them.
   logic [4:0]  cfg_k = 5'd16;
   logic [2:0]  cfg_emb_len = 3'd4;
   logic [15:0] cfg_query [4] = '{default: '0};

   // Kept list of the set in progress, nearest first.
   longint      near_dist [tknn_pkg::K_MAX];
   logic [31:0] near_id [tknn_pkg::K_MAX];
   int          near_count = 0;

   cand_item_type      pending_cands [$];
   nearest_result_type expected_results [$];
   cand_item_type      offered_cand;
   int                 cands_in_flight = 0;
   int                 error_count = 0;
   int                 send_gap_left = 0;
   int                 recv_gap_left = 0;
   int                 hold_left = 0;
   bit                 send_idle_on = 1'b1;
   bit                 recv_idle_on = 1'b1;
   bit                 hold_results_req = 1'b0;

   top_k_nearest_by_squared_distance_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cand_id         (req_cand_id),
      .req_elem_0          (req_elem_0),
      .req_elem_1          (req_elem_1),
      .req_elem_2          (req_elem_2),
      .req_elem_3          (req_elem_3),
      .req_last_item       (req_last_item),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_id       (rsp_result_id),
      .rsp_result_distance (rsp_result_distance),
      .rsp_result_last     (rsp_result_last),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic int effective_k();
      int k;
      k = cfg_k;
      if (k < 1) k = 1;
      if (k > tknn_pkg::K_MAX) k = tknn_pkg::K_MAX;
      return k;
   endfunction

   function automatic longint squared_distance(cand_item_type c);
      int     lanes;
      longint diff;
      longint sum;
      lanes = cfg_emb_len;
      if (lanes < 1) lanes = 1;
      if (lanes > tknn_pkg::EMB_LANES) lanes = tknn_pkg::EMB_LANES;
      sum = 0;
      for (int i = 0; i < lanes; i++) begin
         diff = longint'($signed(c.elem[i])) - longint'($signed(cfg_query[i]));
         sum += diff * diff;
      end
      return sum;
   endfunction

   // Inserts behind any kept entry of equal distance, so ties keep the earlier item.
   function automatic void rank_candidate(cand_item_type c);
      int     k;
      int     n;
      int     p;
      int     src;
      longint cand_dist;
      nearest_result_type res;
      k = effective_k();
      cand_dist = squared_distance(c);
      n = (near_count > k) ? k : near_count;
      p = 0;
      while (p < n && near_dist[p] <= cand_dist) p++;
      if (p < k) begin
         if (n < k) n++;
         for (int i = n - 1; i > p; i--) begin
            near_dist[i] = near_dist[i - 1];
            near_id[i] = near_id[i - 1];
         end
         near_dist[p] = cand_dist;
         near_id[p] = c.id;
      end
      near_count = n;
      if (c.last) begin
         for (int r = 0; r < n; r++) begin
            src = n - 1 - r;
            res.id = near_id[src];
            res.sqdist = 34'(near_dist[src]);
            res.last = (src == 0);
            expected_results = {expected_results, res};
         end
         near_count = 0;
      end
   endfunction

   function automatic int pick_idle_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [15:0] pick_elem(logic [15:0] center);
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return 16'($urandom());
      if (r < 40) return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
      if (r < 75) return center + 16'($urandom_range(0, 6) - 3);
      return 16'($urandom_range(0, 16) - 8);
   endfunction

   task automatic push_cand(logic [31:0] id, logic [15:0] e0, logic [15:0] e1,
                            logic [15:0] e2, logic [15:0] e3, logic last);
      cand_item_type c;
      c.id = id;
      c.elem[0] = e0;
      c.elem[1] = e1;
      c.elem[2] = e2;
      c.elem[3] = e3;
      c.last = last;
      pending_cands = {pending_cands, c};
      cands_in_flight++;
   endtask

   task automatic write_csr(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         tknn_pkg::REG_K_USED:  cfg_k = value[4:0];
         tknn_pkg::REG_EMB_LEN: cfg_emb_len = value[2:0];
         default:               cfg_query[2'(idx - tknn_pkg::REG_QUERY_0)] = value[15:0];
      endcase
   endtask

   // Unused upper bits of each register word carry random data.
   task automatic program_search(logic [4:0] k, logic [2:0] len, logic [3:0][15:0] q);
      logic [31:0] v;
      v = $urandom();
      v[4:0] = k;
      write_csr(tknn_pkg::REG_K_USED, v);
      v = $urandom();
      v[2:0] = len;
      write_csr(tknn_pkg::REG_EMB_LEN, v);
      for (int j = 0; j < 4; j++) begin
         v = $urandom();
         v[15:0] = q[j];
         write_csr(tknn_pkg::REG_QUERY_0 + 3'(j), v);
      end
      @(negedge clock);
   endtask

   task automatic wait_for_drain(int settle);
      while (cands_in_flight != 0 || expected_results.size() != 0) @(negedge clock);
      repeat (settle) @(posedge clock);
      @(negedge clock);
   endtask

   always @(posedge clock) begin : cand_driver
      cand_item_type next_cand;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            rank_candidate(offered_cand);
            cands_in_flight--;
         end
         if (!req_valid || req_ready) begin
            if (send_gap_left > 0) begin
               send_gap_left--;
               req_valid <= 1'b0;
            end else if (pending_cands.size() > 0) begin
               next_cand = pending_cands.pop_front();
               offered_cand = next_cand;
               req_cand_id <= next_cand.id;
               req_elem_0 <= next_cand.elem[0];
               req_elem_1 <= next_cand.elem[1];
               req_elem_2 <= next_cand.elem[2];
               req_elem_3 <= next_cand.elem[3];
               req_last_item <= next_cand.last;
               req_valid <= 1'b1;
               if (send_idle_on && $urandom_range(0, 3) == 0) send_gap_left = pick_idle_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      nearest_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected item, id %h distance %0d last %b", $time,
                        rsp_result_id, rsp_result_distance, rsp_result_last);
            end else begin
               want = expected_results.pop_front();
               if (rsp_result_id !== want.id) begin
                  error_count++;
                  $display("%0t: result_id expected %h, got %h", $time, want.id, rsp_result_id);
               end
               if (rsp_result_distance !== want.sqdist) begin
                  error_count++;
                  $display("%0t: result_distance expected %0d, got %0d", $time, want.sqdist,
                           rsp_result_distance);
               end
               if (rsp_result_last !== want.last) begin
                  error_count++;
                  $display("%0t: result_last expected %b, got %b", $time, want.last,
                           rsp_result_last);
               end
            end
         end
         if (hold_results_req) begin
            hold_left = 300;
            hold_results_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (recv_gap_left > 0) begin
            recv_gap_left--;
            rsp_ready <= 1'b0;
         end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
            recv_gap_left = pick_idle_len() - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      logic [3:0][15:0] q;
      logic [4:0]       k;
      logic [2:0]       len;
      cand_item_type    c;
      int               r;
      int               made;
      int               target;
      int               set_len;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: all four lanes, sixteen kept, query at the origin.
      push_cand(32'h0000_0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
      push_cand(32'hFFFF_FFFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
      push_cand(32'h0000_0001, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
      push_cand(32'h0000_0002, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 1'b0);
      push_cand(32'h0000_0003, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 1'b0);
      push_cand(32'h0000_0004, 16'h0002, 16'h0000, 16'h0000, 16'h0000, 1'b1);
      wait_for_drain(12);

      // Two kept on one lane; the equal-distance newcomer is dropped once the list is full.
      q = {16'($urandom()), 16'($urandom()), 16'($urandom()), 16'h7FFF};
      program_search(5'd2, 3'd1, q);
      push_cand(32'd10, 16'h8000, 16'($urandom()), 16'($urandom()), 16'($urandom()), 1'b0);
      push_cand(32'd11, 16'h7FFF, 16'($urandom()), 16'($urandom()), 16'($urandom()), 1'b0);
      push_cand(32'd12, 16'h7FFF, 16'($urandom()), 16'($urandom()), 16'($urandom()), 1'b0);
      push_cand(32'd13, 16'h7FFF, 16'($urandom()), 16'($urandom()), 16'($urandom()), 1'b1);
      wait_for_drain(12);

      // Zero for k and for the length both act as one.
      q = '0;
      program_search(5'd0, 3'd0, q);
      push_cand(32'd20, 16'd5, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
      push_cand(32'd21, 16'hFFFB, 16'h8000, 16'h7FFF, 16'h8000, 1'b0);
      push_cand(32'd22, 16'd3, 16'h1234, 16'h8765, 16'h4321, 1'b1);
      wait_for_drain(12);

      // Over-range k and length clamp to the limits; this is the largest distance.
      q = {4{16'h7FFF}};
      program_search(5'd31, 3'd7, q);
      push_cand(32'd30, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
      wait_for_drain(12);

      // K lowered while a set is half collected.
      q = {16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom())};
      program_search(5'd16, 3'd4, q);
      for (int j = 0; j < 6; j++)
         push_cand($urandom(), pick_elem(q[0]), pick_elem(q[1]), pick_elem(q[2]),
                   pick_elem(q[3]), 1'b0);
      wait_for_drain(30);
      write_csr(tknn_pkg::REG_K_USED, 32'd3);
      @(negedge clock);
      for (int j = 0; j < 3; j++)
         push_cand($urandom(), pick_elem(q[0]), pick_elem(q[1]), pick_elem(q[2]),
                   pick_elem(q[3]), j == 2);
      wait_for_drain(12);

      for (int ph = 0; ph < 11; ph++) begin
         r = $urandom_range(0, 99);
         if (r < 15) k = 5'd1;
         else if (r < 30) k = 5'd16;
         else if (r < 38) k = 5'd0;
         else if (r < 48) k = 5'($urandom_range(17, 31));
         else k = 5'($urandom_range(2, 15));
         r = $urandom_range(0, 99);
         if (r < 10) len = 3'd0;
         else if (r < 20) len = 3'($urandom_range(5, 7));
         else len = 3'($urandom_range(1, 4));
         for (int j = 0; j < 4; j++) begin
            if ($urandom_range(0, 3) == 0)
               q[j] = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
            else
               q[j] = 16'($urandom());
         end
         program_search(k, len, q);
         send_idle_on = (ph % 4 != 3);
         recv_idle_on = (ph % 5 != 2);
         target = 30;
         // Results held back for a long stretch while short sets keep arriving.
         if (ph == 6) begin
            send_idle_on = 1'b0;
            hold_results_req = 1'b1;
            target = 40;
         end
         made = 0;
         while (made < target) begin
            if (ph == 6) set_len = $urandom_range(1, 3);
            else if ($urandom_range(0, 9) == 0) set_len = 1;
            else set_len = $urandom_range(2, 20);
            for (int j = 0; j < set_len; j++) begin
               c.id = $urandom();
               for (int l = 0; l < 4; l++) c.elem[l] = pick_elem(q[l]);
               c.last = (j == set_len - 1);
               pending_cands = {pending_cands, c};
               cands_in_flight++;
               made++;
            end
         end
         wait_for_drain(12);
      end

      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      wait_for_drain(40);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- top_k_nearest_by_squared_distance_unit.f -----
rtl/tknn_pkg.sv
rtl/tknn_csr.sv
rtl/tknn_front.sv
rtl/tknn_queue.sv
rtl/tknn_select.sv
rtl/top_k_nearest_by_squared_distance_unit.sv
sim/testbench.sv
